### sv/pdlf_pkg.sv
package pdlf_pkg;

    localparam int ReflW    = 7;
    localparam int LevelW   = 10;
    localparam int GainW    = 10;
    localparam int SpeedW   = 7;
    localparam int PowerW   = 8;
    localparam int ErrW     = 8;
    localparam int DiffW    = ErrW + 1;
    localparam int TurnW    = 20;
    localparam int SumW     = TurnW + 1;
    localparam int QuotW    = SumW - 8;
    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 10;

    localparam int PowerLimit = 100;

    // turn magnitude thresholds, Q8
    localparam logic [TurnW-1:0] TurnSharp  = TurnW'(25 * 256);
    localparam logic [TurnW-1:0] TurnMedium = TurnW'(15 * 256);
    localparam logic [TurnW-1:0] TurnGentle = TurnW'(8 * 256);

    typedef enum logic [CfgIdxW-1:0] {
        REG_PROP_GAIN   = 4'd0,
        REG_DERIV_GAIN  = 4'd1,
        REG_TARGET      = 4'd2,
        REG_BASE_SPEED  = 4'd3,
        REG_CURVE_SPEED = 4'd4,
        REG_BLUE_LEVEL  = 4'd5,
        REG_BLUE_MARGIN = 4'd6,
        REG_BLUE_ENABLE = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [GainW-1:0]  prop_gain_q8;
        logic [GainW-1:0]  deriv_gain_q8;
        logic [ReflW-1:0]  target_level;
        logic [SpeedW-1:0] base_speed;
        logic [SpeedW-1:0] curve_speed;
        logic [LevelW-1:0] blue_level;
        logic [LevelW-1:0] blue_margin;
        logic              blue_enable;
    } cfg_t;

    localparam cfg_t CfgReset = '{
        prop_gain_q8:  10'd205,
        deriv_gain_q8: 10'd51,
        target_level:  7'd25,
        base_speed:    7'd50,
        curve_speed:   7'd20,
        blue_level:    10'd120,
        blue_margin:   10'd50,
        blue_enable:   1'b1
    };

    typedef struct packed {
        logic [ReflW-1:0]  reflection;
        logic [LevelW-1:0] red_level;
        logic [LevelW-1:0] green_level;
        logic [LevelW-1:0] blue_level_in;
    } sample_t;

    typedef struct packed {
        logic signed [PowerW-1:0] left_power;
        logic signed [PowerW-1:0] right_power;
        logic                     blue_seen;
    } result_t;

    // floor(s * 70 / 100) = floor(7s / 10); 7s < 1024 so *205 >> 11 is exact
    function automatic logic [SpeedW-1:0] speed_70(input logic [SpeedW-1:0] s);
        logic [9:0]  x7;
        logic [17:0] p;
        x7 = 10'(s) * 10'd7;
        p  = 18'(x7) * 18'd205;
        return p[17:11];
    endfunction

    // floor(s * 50 / 100)
    function automatic logic [SpeedW-1:0] speed_50(input logic [SpeedW-1:0] s);
        return s >> 1;
    endfunction

    // Q8 to integer, truncated toward zero, then saturated
    function automatic logic signed [PowerW-1:0] to_power(input logic signed [SumW-1:0] v);
        logic signed [QuotW-1:0] q;
        logic signed [QuotW-1:0] q_max;
        logic signed [QuotW-1:0] q_min;
        q     = v[SumW-1:8];
        q_max = QuotW'(PowerLimit);
        q_min = -QuotW'(PowerLimit);
        if (v[SumW-1] && (v[7:0] != 8'd0))
        begin
            q = q + QuotW'(1);
        end
        if (q > q_max)
        begin
            return PowerW'(PowerLimit);
        end
        else if (q < q_min)
        begin
            return -PowerW'(PowerLimit);
        end
        return q[PowerW-1:0];
    endfunction

endpackage

### sv/pdlf_if.sv
interface pdlf_sample_if;
    import pdlf_pkg::*;
    logic              valid;
    logic              ready;
    logic [ReflW-1:0]  reflection;
    logic [LevelW-1:0] red_level;
    logic [LevelW-1:0] green_level;
    logic [LevelW-1:0] blue_level_in;

    modport source (output valid, reflection, red_level, green_level, blue_level_in,
                    input ready);
    modport sink   (input valid, reflection, red_level, green_level, blue_level_in,
                    output ready);
endinterface

interface pdlf_result_if;
    import pdlf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [PowerW-1:0] left_power;
    logic signed [PowerW-1:0] right_power;
    logic                     blue_seen;

    modport source (output valid, left_power, right_power, blue_seen, input ready);
    modport sink   (input valid, left_power, right_power, blue_seen, output ready);
endinterface

interface pdlf_cfg_if;
    import pdlf_pkg::*;
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/pdlf_cfg_regs.sv
module pdlf_cfg_regs
    import pdlf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pdlf_cfg_if.sink   cfg,
    output cfg_t       regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PROP_GAIN:   regs_next.prop_gain_q8  = cfg.data[GainW-1:0];
                REG_DERIV_GAIN:  regs_next.deriv_gain_q8 = cfg.data[GainW-1:0];
                REG_TARGET:      regs_next.target_level  = cfg.data[ReflW-1:0];
                REG_BASE_SPEED:  regs_next.base_speed    = cfg.data[SpeedW-1:0];
                REG_CURVE_SPEED: regs_next.curve_speed   = cfg.data[SpeedW-1:0];
                REG_BLUE_LEVEL:  regs_next.blue_level    = cfg.data[LevelW-1:0];
                REG_BLUE_MARGIN: regs_next.blue_margin   = cfg.data[LevelW-1:0];
                REG_BLUE_ENABLE: regs_next.blue_enable   = cfg.data[0];
                default:         regs_next = regs_reg; // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= CfgReset;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

### sv/pdlf_law.sv
module pdlf_law
    import pdlf_pkg::*;
(
    input  cfg_t                   cfg,
    input  sample_t                smp,
    input  logic signed [ErrW-1:0] last_error,
    output result_t                res,
    output logic signed [ErrW-1:0] err
);

    logic signed [DiffW-1:0]  diff;
    logic signed [TurnW-1:0]  p_term;
    logic signed [TurnW-1:0]  d_term;
    logic signed [TurnW-1:0]  turn;
    logic        [TurnW-1:0]  mag;
    logic        [SpeedW-1:0] speed;
    logic signed [SumW-1:0]   speed_q8;
    logic signed [SumW-1:0]   turn_ext;
    logic        [LevelW:0]   red_lim;
    logic        [LevelW:0]   green_lim;
    logic                     is_blue;

    // blue mark: detection on, blue above blue_level and dominant over red and green by more than the margin
    assign red_lim   = {1'b0, smp.red_level} + {1'b0, cfg.blue_margin};
    assign green_lim = {1'b0, smp.green_level} + {1'b0, cfg.blue_margin};
    assign is_blue   = cfg.blue_enable
                    && (smp.blue_level_in > cfg.blue_level)
                    && ({1'b0, smp.blue_level_in} > red_lim)
                    && ({1'b0, smp.blue_level_in} > green_lim);

    assign err  = $signed({1'b0, smp.reflection}) - $signed({1'b0, cfg.target_level});
    assign diff = $signed({err[ErrW-1], err}) - $signed({last_error[ErrW-1], last_error});

    assign p_term = TurnW'($signed({1'b0, cfg.prop_gain_q8})) * TurnW'(err);
    assign d_term = TurnW'($signed({1'b0, cfg.deriv_gain_q8})) * TurnW'(diff);
    assign turn   = p_term + d_term;
    assign mag    = turn[TurnW-1] ? TurnW'(-turn) : TurnW'(turn);

    always_comb
    begin
        priority if (mag > TurnSharp)
        begin
            speed = cfg.curve_speed;
        end
        else if (mag > TurnMedium)
        begin
            speed = speed_50(cfg.base_speed);
        end
        else if (mag > TurnGentle)
        begin
            speed = speed_70(cfg.base_speed);
        end
        else
        begin
            speed = cfg.base_speed;
        end
    end

    assign speed_q8 = $signed({{(SumW-SpeedW-8){1'b0}}, speed, 8'd0});
    assign turn_ext = $signed({turn[TurnW-1], turn});

    always_comb
    begin
        if (is_blue)
        begin
            res.left_power  = '0;
            res.right_power = '0;
            res.blue_seen   = 1'b1;
        end
        else
        begin
            res.left_power  = to_power(speed_q8 - turn_ext);
            res.right_power = to_power(speed_q8 + turn_ext);
            res.blue_seen   = 1'b0;
        end
    end

endmodule

### sv/pd_line_follower_adaptive_speed.sv
// PD line follower with adaptive speed. Each item on "sample" is one sensor
// reading; each produces exactly one item on "result" holding left/right motor
// power (-100..100) and a blue flag. A sample classed as blue (detection on,
// blue above blue_level and above red and green by more than blue_margin)
// gives zero power, sets blue_seen and leaves the stored error alone. Any
// other sample forms e = reflection - target_level and a Q8 PD turn value;
// base speed drops to 70 %, 50 % or curve_speed as |turn| grows, and the
// powers are speed -/+ turn, truncated toward zero and saturated.
// Rate: one item per clock while results are taken. The accepting edge loads the
// input register; the result register loads from it once it frees, and result
// valid rises with that load. Throughput rests on the last_error loop, which
// closes through the law logic between the input register and the result
// register. The input stalls only while both registers are full and the
// result is not taken.
// Registers are written through "cfg" (always ready) and should only change
// while no item is in flight.
module pd_line_follower_adaptive_speed
    import pdlf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pdlf_sample_if.sink  sample,
    pdlf_result_if.source result,
    pdlf_cfg_if.sink     cfg
);

    cfg_t                   regs;

    // input stage
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    sample_t                s1_sample_reg;

    // result stage
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                out_result_reg;

    // PD state: error of the last non-blue sample
    logic signed [ErrW-1:0] last_error_reg;
    logic signed [ErrW-1:0] last_error_next;

    result_t                law_res;
    logic signed [ErrW-1:0] law_err;
    logic                   advance;
    logic                   in_fire;
    logic                   s1_fire;

    pdlf_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pdlf_law u_law (
        .cfg        (regs),
        .smp        (s1_sample_reg),
        .last_error (last_error_reg),
        .res        (law_res),
        .err        (law_err)
    );

    // result register frees when empty or being taken; input stage moves then
    assign advance      = !out_valid_reg || result.ready;
    assign sample.ready = !s1_valid_reg || advance;
    assign in_fire      = sample.valid && sample.ready;
    assign s1_fire      = s1_valid_reg && advance;

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        out_valid_next  = out_valid_reg;
        last_error_next = last_error_reg;
        if (sample.ready)
        begin
            s1_valid_next = sample.valid;
        end
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
        // blue samples leave the error history untouched
        if (s1_fire && !law_res.blue_seen)
        begin
            last_error_next = law_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_error_reg <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            last_error_reg <= last_error_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sample_reg.reflection    <= sample.reflection;
            s1_sample_reg.red_level     <= sample.red_level;
            s1_sample_reg.green_level   <= sample.green_level;
            s1_sample_reg.blue_level_in <= sample.blue_level_in;
        end
        if (s1_fire)
        begin
            out_result_reg <= law_res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.left_power  = out_result_reg.left_power;
    assign result.right_power = out_result_reg.right_power;
    assign result.blue_seen   = out_result_reg.blue_seen;

    // blue result carries zero power
    a_blue_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_result_reg.blue_seen) |->
            (out_result_reg.left_power == '0 && out_result_reg.right_power == '0))
        else $error("blue result with non-zero power");

    // powers stay inside the saturation limits
    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (out_result_reg.left_power <= PowerW'(PowerLimit)
          && out_result_reg.left_power >= -PowerW'(PowerLimit)
          && out_result_reg.right_power <= PowerW'(PowerLimit)
          && out_result_reg.right_power >= -PowerW'(PowerLimit)))
        else $error("motor power out of range");

    // a blue item must not disturb the error history
    a_blue_keeps_error: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && law_res.blue_seen) |=> $stable(last_error_reg))
        else $error("last error changed on blue sample");

    // error history only moves when an item leaves the input stage
    a_error_moves_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(last_error_reg))
        else $error("last error changed without an item");

    // input backpressure only when the input stage is full and stuck
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (s1_valid_reg && out_valid_reg && !result.ready))
        else $error("input stalled without cause");

endmodule

### test/tb_pd_line_follower_adaptive_speed.sv
module tb_pd_line_follower_adaptive_speed;
    import pdlf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandPhases = 9;
    localparam int PhaseItems = 150;
    localparam int HoldCycles = 80;
    localparam int TailCycles = 4;     // margin after the last result is back
    localparam int IdlePct    = 29;

    logic clk = 1'b0;
    logic rst_n;

    pdlf_sample_if sample_ch ();
    pdlf_result_if result_ch ();
    pdlf_cfg_if    cfg_ch ();

    pd_line_follower_adaptive_speed i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    // Shadow copy of the register file and of the stored error
    cfg_t    shadow_cfg = CfgReset;
    int      prev_err   = 0;

    sample_t readings_pending[$];   // waiting for the driver
    result_t powers_due[$];         // expected results, oldest first

    int  n_queued    = 0;
    int  n_taken     = 0;
    int  n_errors    = 0;
    bit  sample_took = 1'b0;

    // Traffic shaping: steady and hold_asks are written only by the sequencing block
    bit  steady    = 1'b0;          // no idling on either side
    int  hold_asks = 0;             // bumped to ask for a receiver hold-off
    int  hold_seen = 0;
    int  hold_left = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        n_errors++;
    endtask

    // Register write as the block sees it: unknown indexes are dropped,
    // data is cut to the width of the field.
    function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                      input logic [CfgDataW-1:0] val);
        case (idx)
            REG_PROP_GAIN:   shadow_cfg.prop_gain_q8  = val[GainW-1:0];
            REG_DERIV_GAIN:  shadow_cfg.deriv_gain_q8 = val[GainW-1:0];
            REG_TARGET:      shadow_cfg.target_level  = val[ReflW-1:0];
            REG_BASE_SPEED:  shadow_cfg.base_speed    = val[SpeedW-1:0];
            REG_CURVE_SPEED: shadow_cfg.curve_speed   = val[SpeedW-1:0];
            REG_BLUE_LEVEL:  shadow_cfg.blue_level    = val[LevelW-1:0];
            REG_BLUE_MARGIN: shadow_cfg.blue_margin   = val[LevelW-1:0];
            REG_BLUE_ENABLE: shadow_cfg.blue_enable   = val[0];
            default: ;
        endcase
    endfunction

    // Motor powers for one reading; updates the stored error on a trace
    // sample, leaves it alone on a blue one.
    function automatic result_t motor_powers(input sample_t s);
        int      err;
        int      turn;
        int      mag;
        int      speed;
        int      lp;
        int      rp;
        result_t r;
        r = '0;
        if (shadow_cfg.blue_enable && (s.blue_level_in > shadow_cfg.blue_level) &&
            (int'(s.blue_level_in) > int'(s.red_level) + int'(shadow_cfg.blue_margin)) &&
            (int'(s.blue_level_in) > int'(s.green_level) + int'(shadow_cfg.blue_margin)))
        begin
            r.blue_seen = 1'b1;
            return r;
        end
        err  = int'(s.reflection) - int'(shadow_cfg.target_level);
        turn = int'(shadow_cfg.prop_gain_q8) * err +
               int'(shadow_cfg.deriv_gain_q8) * (err - prev_err);
        prev_err = err;
        mag = (turn < 0) ? -turn : turn;
        if (mag > int'(TurnSharp))
        begin
            speed = int'(shadow_cfg.curve_speed);
        end
        else if (mag > int'(TurnMedium))
        begin
            speed = int'(shadow_cfg.base_speed) * 50 / 100;
        end
        else if (mag > int'(TurnGentle))
        begin
            speed = int'(shadow_cfg.base_speed) * 70 / 100;
        end
        else
        begin
            speed = int'(shadow_cfg.base_speed);
        end
        // integer division truncates toward zero, as wanted
        lp = (speed * 256 - turn) / 256;
        rp = (speed * 256 + turn) / 256;
        lp = (lp > PowerLimit) ? PowerLimit : ((lp < -PowerLimit) ? -PowerLimit : lp);
        rp = (rp > PowerLimit) ? PowerLimit : ((rp < -PowerLimit) ? -PowerLimit : rp);
        r.left_power  = PowerW'(lp);
        r.right_power = PowerW'(rp);
        return r;
    endfunction

    task automatic queue_reading(input int refl, input int red, input int green,
                                 input int blue);
        sample_t s;
        s.reflection    = ReflW'(refl);
        s.red_level     = LevelW'(red);
        s.green_level   = LevelW'(green);
        s.blue_level_in = LevelW'(blue);
        readings_pending.push_back(s);
        n_queued++;
    endtask

    // Mostly near the set point so all speed tiers are hit; a quarter of
    // the colours lean blue so the classifier gets exercised.
    task automatic queue_random_reading();
        int refl;
        int red;
        int green;
        int blue;
        if ($urandom_range(0, 3) != 0)
        begin
            refl = int'(shadow_cfg.target_level) + $urandom_range(0, 60) - 30;
            refl = (refl < 0) ? 0 : ((refl > 127) ? 127 : refl);
        end
        else
        begin
            refl = $urandom_range(0, 127);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            blue  = $urandom_range(600, 1023);
            red   = $urandom_range(0, 300);
            green = $urandom_range(0, 300);
        end
        else
        begin
            blue  = $urandom_range(0, 1023);
            red   = $urandom_range(0, 1023);
            green = $urandom_range(0, 1023);
        end
        queue_reading(refl, red, green, blue);
    endtask

    // Writes all eight registers in order, then one stray write to an
    // index past the end, which the block must ignore.
    task automatic program_regs(input logic [CfgDataW-1:0] vals [8]);
        int                  k;
        logic [CfgIdxW-1:0]  stray;
        stray = CfgIdxW'(REG_BLUE_ENABLE) + CfgIdxW'($urandom_range(1, 8));
        for (k = 0; k <= 8; k++)
        begin
            @(negedge clk);
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= (k < 8) ? CfgIdxW'(k) : stray;
            cfg_ch.data  <= (k < 8) ? vals[k] : CfgDataW'($urandom_range(0, 1023));
            do
                @(posedge clk);
            while (!cfg_ch.ready);
            apply_reg(cfg_ch.index, cfg_ch.data);
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Block is idle once every reading is taken and every result is back
    task automatic drain();
        while (n_taken != n_queued || powers_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TailCycles) @(posedge clk);
    endtask

    // Sample driver: holds an item until taken, idles at random
    always @(negedge clk)
    begin
        if (rst_n && !(sample_ch.valid && !sample_took))
        begin
            if (readings_pending.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePct))
            begin
                sample_ch.valid         <= 1'b1;
                sample_ch.reflection    <= readings_pending[0].reflection;
                sample_ch.red_level     <= readings_pending[0].red_level;
                sample_ch.green_level   <= readings_pending[0].green_level;
                sample_ch.blue_level_in <= readings_pending[0].blue_level_in;
                void'(readings_pending.pop_front());
            end
            else
            begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // Result ready: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= steady || ($urandom_range(0, 99) >= IdlePct);
            end
        end
    end

    // Accepted readings go through the predictor straight away
    always @(posedge clk)
    begin : take_readings
        sample_t s;
        sample_took <= sample_ch.valid && sample_ch.ready;
        if (rst_n && sample_ch.valid && sample_ch.ready)
        begin
            s.reflection    = sample_ch.reflection;
            s.red_level     = sample_ch.red_level;
            s.green_level   = sample_ch.green_level;
            s.blue_level_in = sample_ch.blue_level_in;
            powers_due.push_back(motor_powers(s));
            n_taken++;
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (powers_due.size() == 0)
            begin
                report_mismatch("result item with nothing expected");
            end
            else
            begin
                want = powers_due.pop_front();
                if (result_ch.left_power !== want.left_power)
                begin
                    report_mismatch($sformatf("left_power %0d, want %0d",
                                              result_ch.left_power, want.left_power));
                end
                if (result_ch.right_power !== want.right_power)
                begin
                    report_mismatch($sformatf("right_power %0d, want %0d",
                                              result_ch.right_power, want.right_power));
                end
                if (result_ch.blue_seen !== want.blue_seen)
                begin
                    report_mismatch($sformatf("blue_seen %0b, want %0b",
                                              result_ch.blue_seen, want.blue_seen));
                end
            end
        end
    end

    // Sequencing: reset, directed items, then randomly configured phases
    initial
    begin : sequencer
        logic [CfgDataW-1:0] vals [8];
        int                  phase;
        int                  k;
        int                  n;
        int                  pick;

        rst_n                   = 1'b0;
        sample_ch.valid         = 1'b0;
        sample_ch.reflection    = '0;
        sample_ch.red_level     = '0;
        sample_ch.green_level   = '0;
        sample_ch.blue_level_in = '0;
        result_ch.ready         = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = '0;
        cfg_ch.data             = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: field extremes and the edges of the blue test
        queue_reading(0, 0, 0, 0);
        queue_reading(127, 1023, 1023, 1023);
        queue_reading(25, 0, 0, 0);                 // zero error
        queue_reading(60, 0, 0, 1023);              // clearly blue
        queue_reading(90, 0, 0, 120);               // blue equal to level: trace
        queue_reading(10, 0, 0, 121);               // just above level: blue
        queue_reading(40, 150, 0, 200);             // margin over red not exceeded
        queue_reading(5, 150, 150, 201);            // just past margin: blue
        queue_reading(70, 150, 151, 201);           // green within margin: trace
        queue_reading(0, 1023, 0, 0);               // red dominant: trace
        drain();

        // Whole-number gain, no derivative: land on each speed tier boundary.
        // Blue test disabled with zero level and margin.
        vals = '{10'd256, 10'd0, 10'd50, 10'd100, 10'd0, 10'd0, 10'd0, 10'd0};
        program_regs(vals);
        queue_reading(58, 0, 0, 0);                 // |turn| exactly 8
        queue_reading(59, 0, 0, 0);
        queue_reading(65, 0, 0, 0);                 // exactly 15
        queue_reading(66, 0, 0, 0);
        queue_reading(75, 0, 0, 0);                 // exactly 25
        queue_reading(76, 0, 0, 0);
        queue_reading(41, 0, 0, 0);
        queue_reading(34, 0, 0, 0);
        queue_reading(24, 0, 0, 0);
        queue_reading(127, 0, 0, 1023);             // would be blue if enabled
        queue_reading(0, 1023, 1023, 0);
        queue_reading(50, 0, 0, 0);
        drain();

        for (phase = 0; phase < RandPhases; phase++)
        begin
            // first phase all zero, second all ones, then mixed
            for (k = 0; k < 8; k++)
            begin
                pick = (phase == 0) ? 0 : ((phase == 1) ? 1 : $urandom_range(0, 7));
                if (pick == 0)
                begin
                    vals[k] = '0;
                end
                else if (pick == 1)
                begin
                    vals[k] = '1;
                end
                else
                begin
                    case (k)
                        REG_PROP_GAIN, REG_DERIV_GAIN:
                            vals[k] = CfgDataW'($urandom_range(0, 600));
                        REG_TARGET, REG_BASE_SPEED, REG_CURVE_SPEED:
                            vals[k] = CfgDataW'($urandom_range(0, 100));
                        REG_BLUE_LEVEL:
                            vals[k] = CfgDataW'($urandom_range(0, 400));
                        REG_BLUE_MARGIN:
                            vals[k] = CfgDataW'($urandom_range(0, 200));
                        default:
                            vals[k] = CfgDataW'($urandom_range(0, 1));
                    endcase
                end
            end
            program_regs(vals);

            // phases 4 and 6 send flat out; in phase 4 the receiver also stalls,
            // so the pipeline fills and the input is held off (back-pressure)
            steady = (phase == 4) || (phase == 6);
            if (phase == 4)
            begin
                hold_asks++;
            end
            for (n = 0; n < PhaseItems; n++)
            begin
                queue_random_reading();
            end
            drain();
            steady = 1'b0;
        end

        if (n_errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("TIMEOUT: %0d items still expected", powers_due.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
